@@ design/pw_pkg.sv @@
// ----------------------------------------------------------------------------
// pw_pkg
// Request and result types, entry bit positions, level and size codes for the
// four-level page walker.
// ----------------------------------------------------------------------------
package pw_pkg;

    localparam int ENTRIES_PER_TABLE = 512;
    localparam int SLOT_W            = 9;
    localparam int ENTRY_W           = 64;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_XLATE = 1'b1;

    localparam logic [1:0] PSIZE_4K = 2'd0;
    localparam logic [1:0] PSIZE_2M = 2'd1;
    localparam logic [1:0] PSIZE_1G = 2'd2;

    localparam logic [1:0] LVL_ROOT = 2'd0;
    localparam logic [1:0] LVL_PDPT = 2'd1;
    localparam logic [1:0] LVL_PD   = 2'd2;
    localparam logic [1:0] LVL_PT   = 2'd3;

    localparam int BIT_PRESENT = 0;
    localparam int BIT_LARGE   = 7;

    typedef struct packed {
        logic        cmd;
        logic [14:0] entry_index;
        logic [63:0] entry_value;
        logic [5:0]  root_page;
        logic [63:0] virt_addr;
    } req_t;

    typedef struct packed {
        logic [51:0] phys_addr;
        logic        mapped;
        logic [1:0]  size_code;
        logic        table_fault;
    } res_t;

    typedef struct packed {
        logic busy;
        logic rd_en;
    } walk_stat_t;

    function automatic logic [SLOT_W-1:0] va_slot(input logic [47:0] va,
                                                  input logic [1:0]  lvl);
        logic [SLOT_W-1:0] s;
        begin
            case (lvl)
                LVL_ROOT: s = va[47:39];
                LVL_PDPT: s = va[38:30];
                LVL_PD:   s = va[29:21];
                LVL_PT:   s = va[20:12];
                default:  s = va[20:12];
            endcase
            return s;
        end
    endfunction

endpackage

@@ design/four_level_page_walk.sv @@
// ----------------------------------------------------------------------------
// four_level_page_walk
// Four-level page-table walker over a local store of table pages.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A write request and a
// translate that is disabled or has its root page beyond the store give their
// result in the next cycle; a walk reads one table entry per level through the
// single synchronous read port of the table store and registers its result
// once the last entry read has been checked. Each result stays on result for
// one cycle with done high and cannot be held off. A new request may be given
// in the cycle its predecessor's result shows. After reset the store is swept
// to zero, one entry per cycle, while busy stays high; the enable register may
// be written during the sweep.
module four_level_page_walk
    import pw_pkg::*;
#(
    parameter int TABLE_PAGES = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output res_t result,
    input  logic cfg_we,
    input  logic cfg_wdata
);

    localparam int PAGE_W      = $clog2(TABLE_PAGES);
    localparam int ADDR_W      = PAGE_W + SLOT_W;
    localparam int STORE_WORDS = TABLE_PAGES * ENTRIES_PER_TABLE;

    logic              clr_active_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              accept;
    logic              wr_sel;
    logic [31:0]       idx_ext;
    walk_stat_t        stat;
    logic [ADDR_W-1:0] rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;

    assign busy    = clr_active_reg | stat.busy;
    assign accept  = start && !busy;
    assign idx_ext = 32'(request.entry_index);
    assign wr_sel  = accept && request.cmd == CMD_WRITE && idx_ext < 32'(STORE_WORDS);

    assign ram_we    = clr_active_reg | wr_sel;
    assign ram_waddr = clr_active_reg ? clr_cnt_reg : idx_ext[ADDR_W-1:0];
    assign ram_wdata = clr_active_reg ? '0 : request.entry_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_cnt_reg <= ADDR_W'(clr_cnt_reg + 1'b1);
            if (clr_cnt_reg == ADDR_W'(STORE_WORDS - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    pw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (stat.rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    pw_walk #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .request   (request),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rd_data   (rd_data),
        .stat      (stat),
        .rd_addr   (rd_addr),
        .done      (done),
        .result    (result)
    );

    a_no_done_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !done)
        else $error("result during store sweep");

    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.cmd == CMD_WRITE) |=> (done && result == '0))
        else $error("write request gave wrong result");

    a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.mapped) |-> (result.phys_addr == '0 && result.size_code == PSIZE_4K))
        else $error("unmapped result not zero");

    a_fault_unmapped: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.table_fault) |-> !result.mapped)
        else $error("fault with mapped result");

endmodule

@@ design/pw_ram.sv @@
// ----------------------------------------------------------------------------
// pw_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32768,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/pw_walk.sv @@
// ----------------------------------------------------------------------------
// pw_walk
// Walk sequencer: one table read per level, level checks, result register and
// the enable register.
// ----------------------------------------------------------------------------
module pw_walk
    import pw_pkg::*;
#(
    parameter int TABLE_PAGES = 64,
    localparam int PAGE_W     = $clog2(TABLE_PAGES),
    localparam int ADDR_W     = PAGE_W + SLOT_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  req_t               request,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic [ENTRY_W-1:0] rd_data,
    output walk_stat_t         stat,
    output logic [ADDR_W-1:0]  rd_addr,
    output logic               done,
    output res_t               result
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic        state_reg, state_next;
    logic [1:0]  level_reg, level_next;
    logic [47:0] va_reg, va_next;
    logic        en_reg;
    logic        done_reg, done_next;
    res_t        res_reg, res_next;
    logic        rd_en;
    logic [39:0] next_page;
    logic [1:0]  level_inc;

    assign next_page = rd_data[51:12];
    assign level_inc = 2'(level_reg + 2'd1);

    always_comb
    begin
        state_next = state_reg;
        level_next = level_reg;
        va_next    = va_reg;
        done_next  = 1'b0;
        res_next   = '0;
        rd_en      = 1'b0;
        rd_addr    = {PAGE_W'(request.root_page), request.virt_addr[47:39]};
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (request.cmd == CMD_XLATE && en_reg)
                    begin
                        if (40'(request.root_page) >= 40'(TABLE_PAGES))
                        begin
                            done_next            = 1'b1;
                            res_next.table_fault = 1'b1;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            level_next = LVL_ROOT;
                            va_next    = request.virt_addr[47:0];
                            state_next = ST_WALK;
                        end
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            ST_WALK:
            begin
                rd_addr = {next_page[PAGE_W-1:0], va_slot(va_reg, level_inc)};
                if (!rd_data[BIT_PRESENT])
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (level_reg == LVL_PDPT && rd_data[BIT_LARGE])
                begin
                    done_next          = 1'b1;
                    res_next.phys_addr = {rd_data[51:30], va_reg[29:0]};
                    res_next.mapped    = 1'b1;
                    res_next.size_code = PSIZE_1G;
                    state_next         = ST_IDLE;
                end
                else if (level_reg == LVL_PD && rd_data[BIT_LARGE])
                begin
                    done_next          = 1'b1;
                    res_next.phys_addr = {rd_data[51:21], va_reg[20:0]};
                    res_next.mapped    = 1'b1;
                    res_next.size_code = PSIZE_2M;
                    state_next         = ST_IDLE;
                end
                else if (level_reg == LVL_PT)
                begin
                    done_next          = 1'b1;
                    res_next.phys_addr = {rd_data[51:12], va_reg[11:0]};
                    res_next.mapped    = 1'b1;
                    res_next.size_code = PSIZE_4K;
                    state_next         = ST_IDLE;
                end
                else if (next_page >= 40'(TABLE_PAGES))
                begin
                    done_next            = 1'b1;
                    res_next.table_fault = 1'b1;
                    state_next           = ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    level_next = level_inc;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            level_reg <= LVL_ROOT;
            en_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                en_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        va_reg  <= va_next;
        res_reg <= res_next;
    end

    assign stat.busy  = (state_reg == ST_WALK);
    assign stat.rd_en = rd_en;
    assign done       = done_reg;
    assign result     = res_reg;

endmodule
